// ----- src/dht_pkg.sv -----
// Shared types and constants for the double-hashing key table.
// Used by dht_ctrl, dht_datapath and double_hash_table_core; no dependencies.
package dht_pkg;

  localparam int TABLE_ENTRIES = 13;
  localparam int KEY_BYTES     = 8;

  localparam int KEY_W      = 64;
  localparam int STATUS_W   = 3;
  localparam int POS_W      = 4;
  localparam int OUT_DATA_W = 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - STATUS_W - POS_W;

  localparam int SLOT_W = $clog2(TABLE_ENTRIES);
  localparam int SUM_W  = $clog2(KEY_BYTES * 255 + 1);

  // Reciprocals for the two constant moduli: floor(x / d) = (x * ceil(2^S / d)) >> S
  // for every SUM_W-bit x when S = SUM_W + ceil(log2 d); a final compare covers the rest.
  localparam int HASH_SHIFT = SUM_W + SLOT_W;
  localparam int RECIP_H1_I = ((1 << HASH_SHIFT) + TABLE_ENTRIES - 1) / TABLE_ENTRIES;
  localparam int RECIP_H2_I = ((1 << HASH_SHIFT) + TABLE_ENTRIES - 2) / (TABLE_ENTRIES - 1);

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_FOUND     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_FULL      = 3'd4,
    ST_EMPTY_KEY = 3'd5
  } dht_status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH_Q,
    S_HASH_R,
    S_REJECT,
    S_READ,
    S_CHECK
  } dht_state_e;

  typedef struct packed {
    logic        clear;
    logic        load;
    logic        hash_q;
    logic        hash_r;
    logic        rd;
    logic        advance;
    logic        write_slot;
    logic        emit;
    logic        use_pos;
    dht_status_e status;
  } dht_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic key_empty;
    logic slot_empty;
    logic slot_match;
    logic probe_last;
    logic is_search;
    logic out_free;
  } dht_sts_t;

endpackage

// ----- src/dht_ctrl.sv -----
// Controller for the double-hashing key table: clear sweep, hash and probe sequencing.
// Depends on dht_pkg; drives dht_datapath through dht_cmd_t and reads dht_sts_t.
module dht_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dht_pkg::dht_sts_t sts_i,
  output dht_pkg::dht_cmd_t cmd_o
);
  import dht_pkg::*;

  dht_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.status = ST_INSERTED;
    in_ready_o = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_HASH_Q;
        end
      end
      S_HASH_Q: begin
        cmd_o.hash_q = 1'b1;
        state_d      = sts_i.key_empty ? S_REJECT : S_HASH_R;
      end
      S_REJECT: begin
        cmd_o.status = ST_EMPTY_KEY;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_HASH_R: begin
        cmd_o.hash_r = 1'b1;
        state_d      = S_READ;
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.slot_empty) begin
          cmd_o.status  = sts_i.is_search ? ST_NOT_FOUND : ST_INSERTED;
          cmd_o.use_pos = !sts_i.is_search;
          if (sts_i.out_free) begin
            cmd_o.emit       = 1'b1;
            cmd_o.write_slot = !sts_i.is_search;
            state_d          = S_IDLE;
          end
        end else if (sts_i.slot_match) begin
          cmd_o.status  = sts_i.is_search ? ST_FOUND : ST_DUPLICATE;
          cmd_o.use_pos = sts_i.is_search;
          if (sts_i.out_free) begin
            cmd_o.emit = 1'b1;
            state_d    = S_IDLE;
          end
        end else if (sts_i.probe_last) begin
          cmd_o.status = sts_i.is_search ? ST_NOT_FOUND : ST_FULL;
          if (sts_i.out_free) begin
            cmd_o.emit = 1'b1;
            state_d    = S_IDLE;
          end
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = S_READ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/dht_datapath.sv -----
// Datapath for the double-hashing key table: key trim and byte sum, hash reduction,
// slot memory, probe stepping and result register. Depends on dht_pkg.
module dht_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  dht_pkg::dht_cmd_t                    cmd_i,
  output dht_pkg::dht_sts_t                    sts_o,
  input  logic                                 in_func_i,
  input  logic [dht_pkg::KEY_W-1:0]            in_key_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic [dht_pkg::OUT_DATA_W-1:0]       out_data_o
);
  import dht_pkg::*;

  localparam logic [SLOT_W-1:0]   TE_W       = SLOT_W'(TABLE_ENTRIES);
  localparam logic [SLOT_W-1:0]   STEP_MOD_W = SLOT_W'(TABLE_ENTRIES - 1);
  localparam logic [SLOT_W-1:0]   LAST_IDX   = SLOT_W'(TABLE_ENTRIES - 1);
  localparam logic [HASH_SHIFT:0] RECIP_H1   = (HASH_SHIFT + 1)'(RECIP_H1_I);
  localparam logic [HASH_SHIFT:0] RECIP_H2   = (HASH_SHIFT + 1)'(RECIP_H2_I);

  logic [KEY_W-1:0] mem [TABLE_ENTRIES];

  logic                   func_q;
  logic [KEY_W-1:0]       key_q;
  logic [SUM_W-1:0]       sum_q;
  logic [SUM_W-1:0]       qa_q, qb_q;
  logic [SLOT_W-1:0]      pos_q, step_q, cnt_q, clr_addr_q;
  logic [KEY_W-1:0]       rd_data_q;
  logic                   out_valid_q;
  logic [STATUS_W-1:0]    out_status_q;
  logic [POS_W-1:0]       out_pos_q;

  logic                   alive;
  logic [7:0]             key_byte;
  logic [KEY_W-1:0]       norm_key;
  logic [SUM_W-1:0]       norm_sum;
  logic [SUM_W+HASH_SHIFT:0] prod_a, prod_b;
  logic [SUM_W+SLOT_W-1:0]   mul_a, mul_b;
  logic [SUM_W-1:0]       rem_a, rem_b;
  logic [SLOT_W-1:0]      h1, h2;
  logic [SLOT_W:0]        pos_sum;
  logic [SLOT_W-1:0]      pos_next;
  logic                   wr_en;
  logic [SLOT_W-1:0]      wr_addr;
  logic [KEY_W-1:0]       wr_data;

  // Keep bytes up to the first zero byte and sum them.
  always_comb begin
    alive    = 1'b1;
    norm_key = '0;
    norm_sum = '0;
    key_byte = '0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      key_byte = in_key_i[8*b +: 8];
      if (key_byte == 8'h00) alive = 1'b0;
      if (alive) begin
        norm_key[8*b +: 8] = key_byte;
        norm_sum           = norm_sum + SUM_W'(key_byte);
      end
    end
  end

  // Quotient by reciprocal, then remainder with one corrective subtract.
  assign prod_a = sum_q * RECIP_H1;
  assign prod_b = sum_q * RECIP_H2;
  assign mul_a  = qa_q * TE_W;
  assign mul_b  = qb_q * STEP_MOD_W;

  always_comb begin
    rem_a = sum_q - mul_a[SUM_W-1:0];
    rem_b = sum_q - mul_b[SUM_W-1:0];
    if (rem_a >= SUM_W'(TABLE_ENTRIES))     rem_a = rem_a - SUM_W'(TABLE_ENTRIES);
    if (rem_b >= SUM_W'(TABLE_ENTRIES - 1)) rem_b = rem_b - SUM_W'(TABLE_ENTRIES - 1);
    h1 = rem_a[SLOT_W-1:0];
    h2 = rem_b[SLOT_W-1:0] + SLOT_W'(1);
  end

  always_comb begin
    pos_sum = {1'b0, pos_q} + {1'b0, step_q};
    if (pos_sum >= {1'b0, TE_W}) begin
      pos_next = SLOT_W'(pos_sum - {1'b0, TE_W});
    end else begin
      pos_next = pos_sum[SLOT_W-1:0];
    end
  end

  // One write port shared by the clear sweep and inserts.
  always_comb begin
    wr_en   = cmd_i.clear | cmd_i.write_slot;
    wr_addr = cmd_i.clear ? clr_addr_q : pos_q;
    wr_data = cmd_i.clear ? '0 : key_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd_i.rd) rd_data_q <= mem[pos_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= in_func_i;
      key_q  <= norm_key;
      sum_q  <= norm_sum;
    end
    if (cmd_i.hash_q) begin
      qa_q <= prod_a[HASH_SHIFT +: SUM_W];
      qb_q <= prod_b[HASH_SHIFT +: SUM_W];
    end
    if (cmd_i.hash_r) begin
      pos_q  <= h1;
      step_q <= h2;
      cnt_q  <= '0;
    end else if (cmd_i.advance) begin
      pos_q <= pos_next;
      cnt_q <= cnt_q + SLOT_W'(1);
    end
    if (cmd_i.emit) begin
      out_status_q <= cmd_i.status;
      out_pos_q    <= cmd_i.use_pos ? POS_W'(pos_q) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) clr_addr_q <= clr_addr_q + SLOT_W'(1);
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.clr_last   = (clr_addr_q == LAST_IDX);
  assign sts_o.key_empty  = (key_q == '0);
  assign sts_o.slot_empty = (rd_data_q == '0);
  assign sts_o.slot_match = (rd_data_q == key_q);
  assign sts_o.probe_last = (cnt_q == LAST_IDX);
  assign sts_o.is_search  = func_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {{OUT_PAD_W{1'b0}}, out_pos_q, out_status_q};

endmodule

// ----- src/double_hash_table_core.sv -----
// Top level of the double-hashing key table: stream ports, controller and datapath.
// Depends on dht_pkg, dht_ctrl and dht_datapath.
//
//   channel   dir  tdata                        tuser
//   s_axis    in   key[63:0]                    func (0 insert, 1 search)
//   m_axis    out  status[2:0], position[6:3]   -
//
// An item runs S_HASH_Q and S_HASH_R, then S_READ and S_CHECK per probe, making 1 to
// TABLE_ENTRIES probes; an empty key goes from S_HASH_Q to S_REJECT. The slot memory's read
// port is registered, hence the separate read and check states. After reset the table is
// cleared one slot a cycle with s_axis_tready low. A result waits in the output register;
// the next key is taken meanwhile and its search stalls on its last step until m_axis drains.
module double_hash_table_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [dht_pkg::KEY_W-1:0]            s_axis_tdata,  // key
  input  logic                                 s_axis_tuser,  // func
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [dht_pkg::OUT_DATA_W-1:0]       m_axis_tdata   // status, position, zero pad
);
  import dht_pkg::*;

  dht_cmd_t cmd;
  dht_sts_t sts;

  dht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dht_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_func_i   (s_axis_tuser),
    .in_key_i    (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ----- verif/double_hash_table_core_tb.sv -----
// Testbench for double_hash_table_core: directed and random insert/search traffic.
// A local model of the slot table predicts each word on m_axis. Needs dht_pkg and the RTL.
module double_hash_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dht_pkg::*;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int DRAIN_CYCLES    = 64;
  localparam int PHASE_WORDS     = 282;

  typedef struct packed {
    dht_status_e            status;
    logic [POS_W-1:0]       position;
  } table_answer_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [KEY_W-1:0]      s_axis_tdata = '0;   // key
  logic                  s_axis_tuser = 1'b0; // func
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // status, position, zero pad

  logic [KEY_W-1:0] shadow_slots [TABLE_ENTRIES];
  table_answer_t    pending_answers [$];
  int               mismatch_count = 0;
  int               idle_cycles = 0;
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;

  double_hash_table_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // Apply one operation to the local table and return the answer the block must give.
  function automatic table_answer_t probe_table(input logic op, input logic [KEY_W-1:0] raw);
    logic [KEY_W-1:0] kept;
    int unsigned      sum;
    int unsigned      slot;
    int unsigned      stride;
    logic             ended;
    logic             done;
    table_answer_t    ans;
    kept  = '0;
    sum   = 0;
    ended = 1'b0;
    // the key stops at its first zero byte
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (raw[8*b +: 8] == 8'd0) ended = 1'b1;
      if (!ended) begin
        kept[8*b +: 8] = raw[8*b +: 8];
        sum += raw[8*b +: 8];
      end
    end
    ans.status   = ST_EMPTY_KEY;
    ans.position = '0;
    if (kept != '0) begin
      slot       = sum % TABLE_ENTRIES;
      stride     = 1 + sum % (TABLE_ENTRIES - 1);
      ans.status = (op == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
      done       = 1'b0;
      for (int j = 0; j < TABLE_ENTRIES && !done; j++) begin
        if (shadow_slots[slot] == '0) begin
          if (op == OP_INSERT) begin
            shadow_slots[slot] = kept;
            ans.status         = ST_INSERTED;
            ans.position       = POS_W'(slot);
          end else begin
            ans.status = ST_NOT_FOUND;
          end
          done = 1'b1;
        end else if (shadow_slots[slot] == kept) begin
          if (op == OP_INSERT) begin
            ans.status = ST_DUPLICATE;
          end else begin
            ans.status   = ST_FOUND;
            ans.position = POS_W'(slot);
          end
          done = 1'b1;
        end else begin
          slot = (slot + stride) % TABLE_ENTRIES;
        end
      end
    end
    return ans;
  endfunction

  // Key of len nonzero bytes, a zero terminator, then random junk above it.
  function automatic logic [KEY_W-1:0] random_key(input int len);
    logic [KEY_W-1:0] k;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (b < len) k[8*b +: 8] = 8'($urandom_range(255, 1));
      else if (b == len) k[8*b +: 8] = 8'd0;
      else k[8*b +: 8] = 8'($urandom_range(255));
    end
    return k;
  endfunction

  // Fill the bytes beyond the terminator of a stored key with junk, at random.
  function automatic logic [KEY_W-1:0] with_junk(input logic [KEY_W-1:0] k);
    int len;
    len = 0;
    while (len < KEY_BYTES && k[8*len +: 8] != 8'd0) len++;
    if (len < KEY_BYTES - 1 && $urandom_range(1) == 1)
      k = k | ({$urandom(), $urandom()} << (8 * (len + 1)));
    return k;
  endfunction

  task automatic send_word(input logic op, input logic [KEY_W-1:0] raw);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= raw;
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_answers.push_back(probe_table(op, raw));
  endtask

  task automatic pause_until_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_keys();
    send_word(OP_INSERT, '0);
    send_word(OP_SEARCH, '0);
    send_word(OP_INSERT, 64'hFFFF_FFFF_FFFF_FF00);
  endtask

  task automatic test_insert_search();
    send_word(OP_INSERT, 64'h0000_0000_0043_4241);
    send_word(OP_INSERT, 64'h0000_0000_0043_4241);
    send_word(OP_SEARCH, 64'h0000_0000_0043_4241);
    send_word(OP_SEARCH, 64'h0000_0000_0000_005A);
  endtask

  task automatic test_key_termination();
    // bytes after the first zero must be ignored everywhere
    send_word(OP_INSERT, 64'hDEAD_BEEF_0000_4241);
    send_word(OP_INSERT, 64'h0000_0000_0000_4241);
    send_word(OP_SEARCH, 64'h1234_0000_5600_4241);
  endtask

  task automatic test_extreme_keys();
    send_word(OP_INSERT, '1);
    send_word(OP_SEARCH, '1);
    send_word(OP_INSERT, 64'h0000_0000_0000_0001);
  endtask

  task automatic test_full_table();
    int filled;
    int a;
    filled = 0;
    foreach (shadow_slots[i]) if (shadow_slots[i] != '0) filled++;
    // same byte sum: every key walks the same probe chain
    a = 10;
    repeat (TABLE_ENTRIES - filled) begin
      send_word(OP_INSERT, {48'd0, 8'(200 - a), 8'(a)});
      a++;
    end
    send_word(OP_INSERT, {48'd0, 8'(200 - a), 8'(a)});
    send_word(OP_SEARCH, {48'd0, 8'(200 - a - 1), 8'(a + 1)});
  endtask

  task automatic test_mixed_traffic(input int words, input int idle_pct, input int stall_pct);
    int               r;
    logic [KEY_W-1:0] k;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (words) begin
      r = $urandom_range(99);
      k = shadow_slots[$urandom_range(TABLE_ENTRIES - 1)];
      if (k == '0) k = random_key($urandom_range(KEY_BYTES, 1));
      if (r < 10) send_word(1'($urandom_range(1)), random_key(0));
      else if (r < 50) send_word(OP_SEARCH, with_junk(k));
      else if (r < 65) send_word(OP_INSERT, with_junk(k));
      else if (r < 85) send_word(OP_INSERT, random_key($urandom_range(KEY_BYTES, 1)));
      else send_word(OP_SEARCH, random_key($urandom_range(KEY_BYTES, 1)));
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin : check_answers
    table_answer_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected word, status %0d position %0d", $time,
                 m_axis_tdata[2:0], m_axis_tdata[6:3]);
        mismatch_count++;
      end else begin
        want = pending_answers.pop_front();
        if (m_axis_tdata[2:0] !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, m_axis_tdata[2:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[6:3] !== want.position) begin
          $display("%0t: position expected %0d got %0d", $time, want.position,
                   m_axis_tdata[6:3]);
          mismatch_count++;
        end
        if (m_axis_tdata[7] !== 1'b0) begin
          $display("%0t: pad bit expected 0 got %b", $time, m_axis_tdata[7]);
          mismatch_count++;
        end
      end
    end
  end

  // Count cycles with no word moving on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: watchdog expired", $time);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    foreach (shadow_slots[i]) shadow_slots[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_keys();
    test_insert_search();
    test_key_termination();
    test_extreme_keys();
    test_full_table();

    test_mixed_traffic(PHASE_WORDS, 0, 0);
    pause_until_drained();
    test_mixed_traffic(PHASE_WORDS, 60, 0);
    test_mixed_traffic(PHASE_WORDS, 0, 60);
    test_mixed_traffic(PHASE_WORDS, 30, 30);

    s_axis_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
